>>> rtl/core/tla_pkg.sv
// ----------------------------------------------------------------------------
// tla_pkg: shared types and constants of the toroidal life automaton
// Board geometry, command codes, controller/datapath interface structs and
// the per-cell B3/S23 rule.
// ----------------------------------------------------------------------------
`default_nettype none

package tla_pkg;

    localparam int MAX_SIDE = 64;
    localparam int ROW_W    = $clog2(MAX_SIDE);
    localparam int SIDE_W   = 7;

    localparam logic [SIDE_W-1:0] SIDE_MIN   = SIDE_W'(3);
    localparam logic [SIDE_W-1:0] SIDE_MAX   = SIDE_W'(MAX_SIDE);
    localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(64);

    localparam logic [1:0] MODE_TOGGLE = 2'd0;
    localparam logic [1:0] MODE_STEP   = 2'd1;
    localparam logic [1:0] MODE_READ   = 2'd2;

    typedef logic [MAX_SIDE-1:0] row_t;

    typedef struct packed {
        logic capture;    // latch the incoming request
        logic cell_rd;    // read the row of the addressed cell
        logic cell_wr;    // apply toggle/read and load the result
        logic gen_start;  // read the last row, clear the pointers
        logic fill_up;    // load the row above row 0
        logic fill_cur;   // load row 0
        logic gen_row;    // write one new row, advance the line buffer
        logic res_plain;  // load a result with the cell flag clear
    } ctrl_cmd_t;

    typedef struct packed {
        logic [1:0] in_mode;
        logic       in_bad;
        logic       last_row;
        logic       res_ready;
    } ctrl_stat_t;

    // Row seen one column to the left, wrapped at the side in use
    function automatic row_t wrap_left(input row_t x, input logic [ROW_W-1:0] side_m1);
        row_t r;
        r    = {x[MAX_SIDE-2:0], x[MAX_SIDE-1]};
        r[0] = x[side_m1];
        return r;
    endfunction

    // Row seen one column to the right, wrapped at the side in use
    function automatic row_t wrap_right(input row_t x, input logic [ROW_W-1:0] side_m1);
        row_t r;
        r          = {x[0], x[MAX_SIDE-1:1]};
        r[side_m1] = x[0];
        return r;
    endfunction

    function automatic logic life_rule(input logic self, input logic [7:0] nb);
        logic [3:0] cnt;
        cnt = 4'd0;
        for (int i = 0; i < 8; i++) begin
            cnt = cnt + {3'b000, nb[i]};
        end
        return (cnt == 4'd3) || (self && (cnt == 4'd2));
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/tla_ctrl.sv
// ----------------------------------------------------------------------------
// tla_ctrl: command sequencer
// Accepts one request at a time and steps the datapath through cell access
// or a row-by-row generation sweep, then hands over the result.
// ----------------------------------------------------------------------------
`default_nettype none

module tla_ctrl
    import tla_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire ctrl_stat_t status,
    output ctrl_cmd_t       cmd
);

    typedef enum logic [7:0] {
        ST_IDLE    = 8'b0000_0001,
        ST_CELL_RD = 8'b0000_0010,
        ST_CELL_WR = 8'b0000_0100,
        ST_GEN_PRE = 8'b0000_1000,
        ST_GEN_F0  = 8'b0001_0000,
        ST_GEN_F1  = 8'b0010_0000,
        ST_GEN_ROW = 8'b0100_0000,
        ST_RESP    = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    if (status.in_mode == MODE_STEP) begin
                        state_next = ST_GEN_PRE;
                    end else if ((status.in_mode == MODE_TOGGLE ||
                                  status.in_mode == MODE_READ) && !status.in_bad) begin
                        state_next = ST_CELL_RD;
                    end else begin
                        state_next = ST_RESP;
                    end
                end
            end
            ST_CELL_RD: begin
                cmd.cell_rd = 1'b1;
                state_next  = ST_CELL_WR;
            end
            ST_CELL_WR: begin
                // hold until the output register can take the result
                if (status.res_ready) begin
                    cmd.cell_wr = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_GEN_PRE: begin
                cmd.gen_start = 1'b1;
                state_next    = ST_GEN_F0;
            end
            ST_GEN_F0: begin
                cmd.fill_up = 1'b1;
                state_next  = ST_GEN_F1;
            end
            ST_GEN_F1: begin
                cmd.fill_cur = 1'b1;
                state_next   = ST_GEN_ROW;
            end
            ST_GEN_ROW: begin
                cmd.gen_row = 1'b1;
                if (status.last_row) begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP: begin
                if (status.res_ready) begin
                    cmd.res_plain = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/core/tla_datapath.sv
// ----------------------------------------------------------------------------
// tla_datapath: board memory, line buffer and cell rules
// Holds the board one row per word, sweeps generations through a three-row
// line buffer with a full row of parallel rules, and owns the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tla_datapath
    import tla_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic [SIDE_W-1:0] cfg_wr_data,
    input  wire logic [1:0]        in_mode,
    input  wire logic [ROW_W-1:0]  in_col,
    input  wire logic [ROW_W-1:0]  in_row,
    input  wire ctrl_cmd_t         cmd,
    output ctrl_stat_t             status,
    input  wire logic              m_tready,
    output logic                   m_tvalid,
    output logic                   cell_alive,
    output logic                   bad_coordinate
);

    // board store and per-row valid bits (a row never written reads dead)
    row_t             board_mem [MAX_SIDE];
    logic [MAX_SIDE-1:0] row_valid_reg, row_valid_next;
    row_t             rd_data_reg;
    logic             rd_vld_reg;

    logic [SIDE_W-1:0] board_side_reg, board_side_next;
    logic [SIDE_W-1:0] side_use;
    logic [ROW_W-1:0]  side_m1;

    logic              toggle_reg, toggle_next;
    logic [ROW_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic              bad_reg, bad_next;

    logic [ROW_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [ROW_W-1:0]  wr_row_reg, wr_row_next;
    row_t              up_reg, up_next;
    row_t              cur_reg, cur_next;
    row_t              first_reg, first_next;

    logic              res_vld_reg, res_vld_next;
    logic              alive_reg, alive_next;
    logic              bad_out_reg, bad_out_next;

    logic              mem_re, mem_we;
    logic [ROW_W-1:0]  mem_ra, mem_wa;
    row_t              mem_wd;
    row_t              rd_row, dn_row, new_row, cell_row;
    row_t              up_l, up_r, cur_l, cur_r, dn_l, dn_r;
    logic              in_bad, cell_bit, last_row, res_ready;

    // side in use: register saturated to the legal range
    always_comb begin
        if (board_side_reg < SIDE_MIN) begin
            side_use = SIDE_MIN;
        end else if (board_side_reg > SIDE_MAX) begin
            side_use = SIDE_MAX;
        end else begin
            side_use = board_side_reg;
        end
        side_m1 = ROW_W'(side_use - SIDE_W'(1));
    end

    assign in_bad = (in_mode == MODE_TOGGLE || in_mode == MODE_READ) &&
                    (({1'b0, in_col} >= side_use) || ({1'b0, in_row} >= side_use));

    assign rd_row    = rd_vld_reg ? rd_data_reg : '0;
    assign last_row  = (wr_row_reg == side_m1);
    assign res_ready = !res_vld_reg || m_tready;

    assign status.in_mode   = in_mode;
    assign status.in_bad    = in_bad;
    assign status.last_row  = last_row;
    assign status.res_ready = res_ready;

    // one row of cell rules; the row below the last one is the saved row 0
    always_comb begin
        dn_row = last_row ? first_reg : rd_row;
        up_l   = wrap_left(up_reg, side_m1);
        up_r   = wrap_right(up_reg, side_m1);
        cur_l  = wrap_left(cur_reg, side_m1);
        cur_r  = wrap_right(cur_reg, side_m1);
        dn_l   = wrap_left(dn_row, side_m1);
        dn_r   = wrap_right(dn_row, side_m1);
        for (int c = 0; c < MAX_SIDE; c++) begin
            if (c <= int'(side_m1)) begin
                new_row[c] = life_rule(cur_reg[c], {up_l[c], up_reg[c], up_r[c],
                                                    cur_l[c], cur_r[c],
                                                    dn_l[c], dn_row[c], dn_r[c]});
            end else begin
                new_row[c] = cur_reg[c];
            end
        end
    end

    assign cell_row = rd_row ^ (row_t'(1) << col_reg);
    assign cell_bit = toggle_reg ? cell_row[col_reg] : rd_row[col_reg];

    // memory port selection
    always_comb begin
        mem_re = cmd.cell_rd | cmd.gen_start | cmd.fill_up | cmd.fill_cur | cmd.gen_row;
        if (cmd.cell_rd) begin
            mem_ra = row_reg;
        end else if (cmd.gen_start) begin
            mem_ra = side_m1;
        end else begin
            mem_ra = rd_ptr_reg;
        end
        mem_we = (cmd.cell_wr && toggle_reg) || cmd.gen_row;
        mem_wa = cmd.gen_row ? wr_row_reg : row_reg;
        mem_wd = cmd.gen_row ? new_row : cell_row;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            board_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            rd_data_reg <= board_mem[mem_ra];
            rd_vld_reg  <= row_valid_reg[mem_ra];
        end
    end

    always_comb begin
        board_side_next = cfg_wr_en ? cfg_wr_data : board_side_reg;

        row_valid_next = row_valid_reg;
        if (mem_we) begin
            row_valid_next[mem_wa] = 1'b1;
        end

        toggle_next = toggle_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        bad_next    = bad_reg;
        if (cmd.capture) begin
            toggle_next = (in_mode == MODE_TOGGLE);
            col_next    = in_col;
            row_next    = in_row;
            bad_next    = in_bad;
        end

        rd_ptr_next = rd_ptr_reg;
        wr_row_next = wr_row_reg;
        if (cmd.gen_start) begin
            rd_ptr_next = '0;
            wr_row_next = '0;
        end else if (cmd.fill_up || cmd.fill_cur || cmd.gen_row) begin
            rd_ptr_next = rd_ptr_reg + ROW_W'(1);
        end
        if (cmd.gen_row) begin
            wr_row_next = wr_row_reg + ROW_W'(1);
        end

        up_next    = up_reg;
        cur_next   = cur_reg;
        first_next = first_reg;
        if (cmd.fill_up) begin
            up_next = rd_row;
        end
        if (cmd.fill_cur) begin
            cur_next   = rd_row;
            first_next = rd_row;
        end
        if (cmd.gen_row) begin
            up_next  = cur_reg;
            cur_next = rd_row;
        end

        res_vld_next = res_vld_reg && !m_tready;
        alive_next   = alive_reg;
        bad_out_next = bad_out_reg;
        if (cmd.cell_wr) begin
            res_vld_next = 1'b1;
            alive_next   = cell_bit;
            bad_out_next = 1'b0;
        end else if (cmd.res_plain) begin
            res_vld_next = 1'b1;
            alive_next   = 1'b0;
            bad_out_next = bad_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            board_side_reg <= SIDE_RESET;
            row_valid_reg  <= '0;
            res_vld_reg    <= 1'b0;
            rd_ptr_reg     <= '0;
            wr_row_reg     <= '0;
        end else begin
            board_side_reg <= board_side_next;
            row_valid_reg  <= row_valid_next;
            res_vld_reg    <= res_vld_next;
            rd_ptr_reg     <= rd_ptr_next;
            wr_row_reg     <= wr_row_next;
        end
    end

    always_ff @(posedge aclk) begin
        toggle_reg  <= toggle_next;
        col_reg     <= col_next;
        row_reg     <= row_next;
        bad_reg     <= bad_next;
        up_reg      <= up_next;
        cur_reg     <= cur_next;
        first_reg   <= first_next;
        alive_reg   <= alive_next;
        bad_out_reg <= bad_out_next;
    end

    assign m_tvalid       = res_vld_reg;
    assign cell_alive     = alive_reg;
    assign bad_coordinate = bad_out_reg;

endmodule

`default_nettype wire

>>> rtl/core/toroidal_life_automaton.sv
// ----------------------------------------------------------------------------
// toroidal_life_automaton: wrapping B3/S23 life board with cell access
// Square board up to 64 x 64 cells, side set by cfg_wr_data, edges wrapping.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel s_*: s_tuser carries the command (0 toggle, 1 generation,
//   2 read), s_tdata the cell column and row. Every request gives one result
//   on m_*: m_tdata bit 0 is the cell state after a toggle or read (else 0),
//   m_tuser flags a coordinate at or beyond the side in use (then nothing changes).
//   Write the side with cfg_wr_en/cfg_wr_data while no request is in flight;
//   values outside 3..64 are clamped.
//   A toggle or read reads the addressed row, then applies the command and
//   loads the result; a bad coordinate or unused command goes straight to
//   loading the result. The generation reads the board memory (one read and
//   one write port) one row a cycle through a three-row line buffer, after
//   fill steps that read the last row and then row 0. One request is in
//   progress at a time: a new one is taken only once the current one has
//   loaded its result. s_tready rises at the same edge that loads the
//   result, so the next request overlaps a waiting result.
//   Reset clears every cell and sets the side to 64. While m_tready is low
//   the result holds and the block finishes its current request only up to
//   the point of loading the next result.
// ----------------------------------------------------------------------------
`default_nettype none

module toroidal_life_automaton
    import tla_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic [SIDE_W-1:0] cfg_wr_data,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [15:0]       s_tdata,   // [5:0] col, [11:6] row, [15:12] zero
    input  wire logic [1:0]        s_tuser,   // [1:0] mode
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [7:0]             m_tdata,   // [0] cell_alive, [7:1] zero
    output logic                   m_tuser    // [0] bad_coordinate
);

    ctrl_cmd_t  cmd;
    ctrl_stat_t status;
    logic       cell_alive;

    tla_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tla_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_mode        (s_tuser),
        .in_col         (s_tdata[5:0]),
        .in_row         (s_tdata[11:6]),
        .cmd            (cmd),
        .status         (status),
        .m_tready       (m_tready),
        .m_tvalid       (m_tvalid),
        .cell_alive     (cell_alive),
        .bad_coordinate (m_tuser)
    );

    assign m_tdata = {7'b000_0000, cell_alive};

endmodule

`default_nettype wire
